[rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants for the C token scanner
// Token kinds, error codes, scan modes and the keyword and operator tables.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned ValueBits    = 64;
  localparam int unsigned PosBits      = 16;
  localparam int unsigned KeywordChars = 8;
  localparam int unsigned NumKeywords  = 32;
  localparam int unsigned NumOps       = 11;

  typedef logic [ValueBits-1:0] value_t;
  typedef logic [PosBits-1:0]   pos_t;

  localparam pos_t   PosMax = {PosBits{1'b1}};
  localparam value_t VMask  = {ValueBits{1'b1}};
  localparam value_t OctLim = ~(VMask >> 3);
  localparam value_t HexLim = ~(VMask >> 4);

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_INT     = 3'd2,
    KIND_FLOAT   = 3'd3,
    KIND_KEYWORD = 3'd4,
    KIND_OP2     = 3'd5,
    KIND_PUNCT   = 3'd6,
    KIND_UNSUP   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HEX_OVF   = 3'd1,
    ERR_HEX_EMPTY = 3'd2,
    ERR_OCT_DIGIT = 3'd3,
    ERR_OCT_OVF   = 3'd4,
    ERR_DEC_OVF   = 3'd5,
    ERR_COMMENT   = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_DEC     = 3'd2,
    MODE_OCT     = 3'd3,
    MODE_HEX     = 3'd4,
    MODE_OP      = 3'd5,
    MODE_COMMENT = 3'd6
  } mode_e;

  // Byte item handed from the front end to the scanner core.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } item_t;

  // One token result.
  typedef struct packed {
    kind_e      kind;
    logic [4:0] sub;
    logic [7:0] pch;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    value_t     val;
    err_e       err;
    logic       last;
  } tok_t;

  // Keywords packed low byte first, zero padded to eight bytes.
  typedef logic [8*KeywordChars-1:0] kw_word_t;

  function automatic kw_word_t kw_pack(input string s);
    kw_word_t w;
    w = '0;
    for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic kw_word_t kw_entry(input int unsigned k);
    kw_word_t w;
    w = '0;
    case (k)
      0: w = kw_pack("auto");      1: w = kw_pack("break");
      2: w = kw_pack("case");      3: w = kw_pack("char");
      4: w = kw_pack("const");     5: w = kw_pack("continue");
      6: w = kw_pack("default");   7: w = kw_pack("do");
      8: w = kw_pack("double");    9: w = kw_pack("else");
      10: w = kw_pack("enum");     11: w = kw_pack("extern");
      12: w = kw_pack("float");    13: w = kw_pack("for");
      14: w = kw_pack("goto");     15: w = kw_pack("if");
      16: w = kw_pack("int");      17: w = kw_pack("long");
      18: w = kw_pack("register"); 19: w = kw_pack("return");
      20: w = kw_pack("short");    21: w = kw_pack("signed");
      22: w = kw_pack("sizeof");   23: w = kw_pack("static");
      24: w = kw_pack("struct");   25: w = kw_pack("switch");
      26: w = kw_pack("typedef");  27: w = kw_pack("union");
      28: w = kw_pack("unsigned"); 29: w = kw_pack("void");
      30: w = kw_pack("volatile"); 31: w = kw_pack("while");
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned k);
    kw_word_t w;
    logic [3:0] n;
    w = kw_entry(k);
    n = '0;
    for (int i = 0; i < KeywordChars; i++) if (w[8*i +: 8] != 8'd0) n = n + 4'd1;
    return n;
  endfunction

  // Two-char operator table: 16 bits per entry, first byte high.
  function automatic logic [15:0] op_entry(input int unsigned k);
    logic [15:0] o;
    case (k)
      0: o = {8'h3c, 8'h3d}; 1: o = {8'h3c, 8'h3c}; 2: o = {8'h3e, 8'h3d};
      3: o = {8'h3e, 8'h3e}; 4: o = {8'h2d, 8'h3e}; 5: o = {8'h2d, 8'h2d};
      6: o = {8'h3d, 8'h3d}; 7: o = {8'h21, 8'h3d}; 8: o = {8'h7c, 8'h7c};
      9: o = {8'h26, 8'h26}; 10: o = {8'h2b, 8'h2b};
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic [15:0] sat16(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_ffff) ? 16'hffff : w[15:0];
  endfunction

endpackage

[rtl/cts_fifo.sv]
// ----------------------------------------------------------------------------
// cts_fifo: two-entry queue of byte items
// Decouples the input side from the scanner core.
// ----------------------------------------------------------------------------
module cts_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cts_pkg::item_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cts_pkg::item_t data_o,
  output logic          empty_o
);
  import cts_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> full_o)
    else $error("full dropped without a pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o)
    else $error("entry appeared without a push");
endmodule

[rtl/cts_scan.sv]
// ----------------------------------------------------------------------------
// cts_scan: scanner core
// Takes a byte a cycle if two result slots are free; writes up to two tokens.
// ----------------------------------------------------------------------------
module cts_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  cts_pkg::item_t in_item_i,
  output logic           in_take_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cts_pkg::tok_t  tok_o
);
  import cts_pkg::*;

  localparam int unsigned QDepth = 4;
  // decimal overflow limit: acc*10+d overflows iff acc > DecLim,
  // or acc == DecLim and d > DecRem
  localparam value_t     DecLim = VMask / value_t'(10);
  localparam logic [3:0] DecRem = 4'(VMask % value_t'(10));

  mode_e      mode_q, mode_d;
  logic [7:0] wbuf_q [KeywordChars];
  logic [7:0] wbuf_d [KeywordChars];
  logic [15:0] run_q, run_d;
  pos_t       tline_q, tline_d, tcol_q, tcol_d, line_q, line_d, col_q, col_d;
  value_t     acc_q, acc_d;
  err_e       ferr_q, ferr_d;
  logic       star_q, star_d;

  tok_t       oq_q [QDepth];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  tok_t       t0, t1;
  logic       e0, e1;
  logic       go;

  assign in_take_o = in_valid_i && (cnt_q <= 3'(QDepth - 2));
  assign go        = in_take_o;
  assign empty_o   = cnt_q == 3'd0;
  assign tok_o     = oq_q[rp_q];

  function automatic tok_t mk(kind_e k, logic [4:0] s, logic [7:0] p, pos_t l,
                              pos_t c, logic [15:0] n, value_t v, err_e e);
    tok_t t;
    t.kind = k; t.sub = s; t.pch = p; t.line = sat16(l); t.col = sat16(c);
    t.len = n; t.val = v; t.err = e; t.last = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       floaty, wd, hit, hx;
    logic [3:0] hv;
    logic [3:0] d;
    logic [4:0] kidx;
    logic       restart;
    logic [63:0] kw;
    value_t      mul;
    err_e        nerr;
    c = in_item_i.ch;
    mode_d = mode_q; wbuf_d = wbuf_q; run_d = run_q; tline_d = tline_q;
    tcol_d = tcol_q; line_d = line_q; col_d = col_q; acc_d = acc_q;
    ferr_d = ferr_q; star_d = star_q;
    t0 = '0; t1 = '0; e0 = 1'b0; e1 = 1'b0; restart = 1'b0;
    floaty = c == 8'h2e || c == 8'h65 || c == 8'h45;
    wd = is_letter(c) || is_digit(c);
    d = c[3:0];
    hx = 1'b1; hv = d;
    if (is_digit(c)) hv = d;
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) hv = 4'(c[3:0] + 4'd9);
    else hx = 1'b0;
    for (int i = 0; i < KeywordChars; i++) kw[8*i +: 8] = wbuf_q[i];
    hit = 1'b0; kidx = '0;
    for (int k = 0; k < NumKeywords; k++) begin
      if (!hit && run_q == 16'(kw_len(k)) &&
          ((kw & ~({64{1'b1}} << (8*kw_len(k)))) == kw_entry(k))) begin
        hit = 1'b1; kidx = 5'(k);
      end
    end
    mul = (acc_q << 3) + (acc_q << 1) + value_t'(d);
    nerr = (ferr_q == ERR_NONE) ? ERR_HEX_EMPTY : ferr_q;
    if (in_item_i.eoi) begin
      unique case (mode_q)
        MODE_WORD: begin
          e0 = 1'b1;
          t0 = hit ? mk(KIND_KEYWORD, kidx, 8'd0, tline_q, tcol_q, run_q, '0, ERR_NONE)
                   : mk(KIND_IDENT, 5'd0, 8'd0, tline_q, tcol_q, run_q, '0, ERR_NONE);
        end
        MODE_DEC, MODE_OCT: begin
          e0 = 1'b1;
          t0 = mk(KIND_INT, 5'd0, 8'd0, tline_q, tcol_q, run_q, acc_q, ferr_q);
        end
        MODE_HEX: begin
          e0 = 1'b1;
          t0 = mk(KIND_INT, 5'd0, 8'd0, tline_q, tcol_q, run_q, acc_q,
                  run_q <= 16'd2 ? nerr : ferr_q);
        end
        MODE_OP: begin
          e0 = 1'b1;
          t0 = mk(KIND_PUNCT, 5'd0, wbuf_q[0], tline_q, tcol_q, 16'd1, '0, ERR_NONE);
        end
        default: ;
      endcase
      e1 = 1'b1;
      t1 = (mode_q == MODE_COMMENT)
         ? mk(KIND_END, 5'd0, 8'd0, tline_q, tcol_q, run_q, '0, ERR_COMMENT)
         : mk(KIND_END, 5'd0, 8'd0, line_q, col_q, 16'd0, '0, ERR_NONE);
      mode_d = MODE_IDLE; run_d = '0; tline_d = pos_t'(1); tcol_d = pos_t'(1);
      line_d = pos_t'(1); col_d = pos_t'(1); acc_d = '0; ferr_d = ERR_NONE;
      star_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_WORD: begin
          if (wd) begin
            if (run_q < 16'(KeywordChars)) wbuf_d[run_q[2:0]] = c;
            if (run_q != 16'hffff) run_d = run_q + 16'd1;
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else begin
            e0 = 1'b1; restart = 1'b1;
            t0 = hit ? mk(KIND_KEYWORD, kidx, 8'd0, tline_q, tcol_q, run_q, '0, ERR_NONE)
                     : mk(KIND_IDENT, 5'd0, 8'd0, tline_q, tcol_q, run_q, '0, ERR_NONE);
          end
        end
        MODE_DEC: begin
          if (is_digit(c)) begin
            if (acc_q > DecLim || (acc_q == DecLim && d > DecRem)) begin
              if (ferr_q == ERR_NONE) ferr_d = ERR_DEC_OVF;
            end else acc_d = mul;
            if (run_q != 16'hffff) run_d = run_q + 16'd1;
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else begin
            e0 = 1'b1; restart = 1'b1;
            t0 = floaty ? mk(KIND_FLOAT, 5'd0, 8'd0, tline_q, tcol_q, run_q, '0, ferr_q)
                        : mk(KIND_INT, 5'd0, 8'd0, tline_q, tcol_q, run_q, acc_q, ferr_q);
          end
        end
        MODE_OCT: begin
          if (run_q == 16'd1 && (c == 8'h78 || c == 8'h58)) begin
            mode_d = MODE_HEX; run_d = run_q + 16'd1;
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else if (is_digit(c)) begin
            ferr_d = ferr_q;
            if (d >= 4'd8 && ferr_q == ERR_NONE) ferr_d = ERR_OCT_DIGIT;
            if ((acc_q & OctLim) != '0) begin
              if (ferr_d == ERR_NONE) ferr_d = ERR_OCT_OVF;
            end else acc_d = (acc_q << 3) + value_t'(d);
            if (run_q != 16'hffff) run_d = run_q + 16'd1;
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else begin
            e0 = 1'b1; restart = 1'b1;
            t0 = floaty ? mk(KIND_FLOAT, 5'd0, 8'd0, tline_q, tcol_q, run_q, '0, ferr_q)
                        : mk(KIND_INT, 5'd0, 8'd0, tline_q, tcol_q, run_q, acc_q, ferr_q);
          end
        end
        MODE_HEX: begin
          if (hx) begin
            if ((acc_q & HexLim) != '0) begin
              if (ferr_q == ERR_NONE) ferr_d = ERR_HEX_OVF;
            end else acc_d = (acc_q << 4) + value_t'(hv);
            if (run_q != 16'hffff) run_d = run_q + 16'd1;
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else begin
            e0 = 1'b1; restart = 1'b1;
            t0 = mk(KIND_INT, 5'd0, 8'd0, tline_q, tcol_q, run_q, acc_q,
                    run_q <= 16'd2 ? nerr : ferr_q);
          end
        end
        MODE_OP: begin
          hit = 1'b0; kidx = '0;
          for (int k = 0; k < NumOps; k++) begin
            if (!hit && op_entry(k) == {wbuf_q[0], c}) begin
              hit = 1'b1; kidx = 5'(k);
            end
          end
          if (hit) begin
            e0 = 1'b1; mode_d = MODE_IDLE;
            t0 = mk(KIND_OP2, kidx, 8'd0, tline_q, tcol_q, 16'd2, '0, ERR_NONE);
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else if (wbuf_q[0] == 8'h2f && c == 8'h2a) begin
            mode_d = MODE_COMMENT; star_d = 1'b0; run_d = run_q + 16'd1;
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else begin
            e0 = 1'b1; restart = 1'b1;
            t0 = mk(KIND_PUNCT, 5'd0, wbuf_q[0], tline_q, tcol_q, 16'd1, '0, ERR_NONE);
          end
        end
        MODE_COMMENT: begin
          if (run_q != 16'hffff) run_d = run_q + 16'd1;
          if (star_q && c == 8'h2f) begin
            mode_d = MODE_IDLE;
            if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end else begin
            star_d = c == 8'h2a;
            if (c == 8'h0a) begin
              if (line_q != PosMax) line_d = line_q + pos_t'(1);
              col_d = pos_t'(1);
            end else if (col_q != PosMax) col_d = col_q + pos_t'(1);
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        mode_d = MODE_IDLE;
        if (c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h20) begin
          if (col_q != PosMax) col_d = col_q + pos_t'(1);
        end else if (c == 8'h0a || c == 8'h0d) begin
          if (line_q != PosMax) line_d = line_q + pos_t'(1);
          col_d = pos_t'(1);
        end else begin
          if (col_q != PosMax) col_d = col_q + pos_t'(1);
          if (is_letter(c) || is_digit(c) || c == 8'h2f || c == 8'h3c || c == 8'h3e ||
              c == 8'h2d || c == 8'h3d || c == 8'h21 || c == 8'h7c || c == 8'h26 ||
              c == 8'h2b) begin
            tline_d = line_q; tcol_d = col_q; run_d = 16'd1;
            ferr_d = ERR_NONE; acc_d = '0; wbuf_d[0] = c;
            if (is_letter(c)) mode_d = MODE_WORD;
            else if (is_digit(c)) begin
              mode_d = (c == 8'h30) ? MODE_OCT : MODE_DEC;
              acc_d = value_t'(d);
            end else mode_d = MODE_OP;
          end else begin
            e1 = 1'b1;
            t1 = (c == 8'h3b || c == 8'h2c || c == 8'h3a || c == 8'h2a || c == 8'h7e ||
                  c == 8'h25 || c == 8'h5e || c == 8'h3f || c == 8'h5b || c == 8'h5d ||
                  c == 8'h7b || c == 8'h7d || c == 8'h28 || c == 8'h29)
               ? mk(KIND_PUNCT, 5'd0, c, line_q, col_q, 16'd1, '0, ERR_NONE)
               : mk(KIND_UNSUP, 5'd0, c, line_q, col_q, 16'd1, '0, ERR_NONE);
          end
        end
      end
    end
    if (e1) t1.last = 1'b1;
    else t0.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      wbuf_q <= wbuf_d;
      if (e0) oq_q[wp_q] <= t0;
      if (e1) oq_q[e0 ? wp_q + 2'd1 : wp_q] <= t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; run_q <= '0; tline_q <= pos_t'(1); tcol_q <= pos_t'(1);
      line_q <= pos_t'(1); col_q <= pos_t'(1); ferr_q <= ERR_NONE; star_q <= 1'b0;
      acc_q <= '0;
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (go) begin
        mode_q <= mode_d; run_q <= run_d; tline_q <= tline_d; tcol_q <= tcol_d;
        line_q <= line_d; col_q <= col_d; ferr_q <= ferr_d; star_q <= star_d;
        acc_q <= acc_d;
        wp_q <= wp_q + 2'(e0) + 2'(e1);
      end
      if (pop_i && !empty_o) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + (go ? 3'(e0) + 3'(e1) : 3'd0) - 3'(pop_i && !empty_o);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(QDepth))
    else $error("result queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && in_item_i.eoi) |=> (mode_q == MODE_IDLE && line_q == pos_t'(1)))
    else $error("end of input did not restore reset state");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (go |-> (e0 || e1 ||
    !in_item_i.eoi)))
    else $error("end of input produced no result");
endmodule

[rtl/c_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// c_token_scanner_core: streaming lexer for a subset of C
// Flow: a byte that completes a token waits in the input queue; the scanner step
// writes the result queue at the edge that takes the byte from there, and the
// token then shows at the outputs and can be popped.
// Throughput: one byte per cycle, set by the combinational scanner step;
// it stalls only when the four-entry result queue lacks room for two tokens.
// Reset: asynchronous, active low; clears queues and all state but wbuf_q.
// ----------------------------------------------------------------------------
module c_token_scanner_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           char_code_i,
  input  logic                 end_of_input_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           kind_o,
  output logic [4:0]           sub_index_o,
  output logic [7:0]           punct_char_o,
  output logic [15:0]          start_line_o,
  output logic [15:0]          start_column_o,
  output logic [15:0]          token_length_o,
  output logic [63:0]          int_value_o,
  output logic [2:0]           error_code_o,
  output logic                 is_last_o
);
  import cts_pkg::*;

  // Front end: byte queue for the input side; full while it holds two bytes.
  item_t in_item, q_item;
  logic  q_empty, take;
  tok_t  tok;

  assign in_item.ch  = char_code_i;
  assign in_item.eoi = end_of_input_i;

  cts_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item), .full_o(full),
    .pop_i(take), .data_o(q_item), .empty_o(q_empty)
  );

  // Back end: scanner core with its own result queue.
  cts_scan u_scan (
    .clk_i, .rst_ni, .in_valid_i(!q_empty), .in_item_i(q_item), .in_take_o(take),
    .pop_i(pop), .empty_o(empty), .tok_o(tok)
  );

  assign kind_o         = tok.kind;
  assign sub_index_o    = tok.sub;
  assign punct_char_o   = tok.pch;
  assign start_line_o   = tok.line;
  assign start_column_o = tok.col;
  assign token_length_o = tok.len;
  assign int_value_o    = tok.val;
  assign error_code_o   = tok.err;
  assign is_last_o      = tok.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni) take |-> !q_empty)
    else $error("scanner took from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result vanished without a pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(kind_o))
    else $error("waiting result changed");
endmodule
